/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions on a clock with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// Scored priority queue package
// Sizes, codes, score constants and the command word between front and back.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 8;

  localparam int TAG_PORT_W = 8;
  localparam int STAG_W     = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
  localparam int SCORE_W    = 7;
  localparam int COUNT_W    = 5;
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int FIFO_DEPTH = 2;

  localparam logic [1:0]         SEV_CRIT    = 2'd3;
  localparam logic [1:0]         SEV_URG     = 2'd2;
  localparam logic [SCORE_W-1:0] SCORE_CRIT  = 7'd50;
  localparam logic [SCORE_W-1:0] SCORE_URG   = 7'd30;
  localparam logic [SCORE_W-1:0] SCORE_NON   = 7'd10;
  localparam logic [SCORE_W-1:0] BONUS_HIGH  = 7'd10;
  localparam logic [SCORE_W-1:0] BONUS_LOW   = 7'd5;
  localparam logic [6:0]         AGE_OLD     = 7'd65;
  localparam logic [6:0]         AGE_YOUNG   = 7'd12;
  localparam logic [3:0]         PAIN_HIGH   = 4'd5;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_POP    = 1'b1
  } spq_req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_e;

  typedef enum logic [1:0] {
    CLS_CRIT = 2'd0,
    CLS_URG  = 2'd1,
    CLS_NON  = 2'd2
  } spq_class_e;

  typedef struct packed {
    logic               is_pop;
    logic [STAG_W-1:0]  tag;
    logic [SCORE_W-1:0] score;
    spq_class_e         cls;
  } spq_cmd_t;

  function automatic logic [TAG_PORT_W-1:0] tag_out(logic [STAG_W-1:0] t);
    logic [STAG_W+TAG_PORT_W-1:0] w;
    w = {{TAG_PORT_W{1'b0}}, t};
    return w[TAG_PORT_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] count_out(logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_W-1:0] w;
    w = {{COUNT_W{1'b0}}, c};
    return w[COUNT_W-1:0];
  endfunction

endpackage

/* hdl/spq_if.sv */
// ----------------------------------------------------------------------------
// Scored priority queue channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] tag;
  logic [1:0] severity;
  logic [6:0] age;
  logic [3:0] pain_level;

  modport source (output valid, req_type, tag, severity, age, pain_level, input ready);
  modport sink   (input valid, req_type, tag, severity, age, pain_level, output ready);
endinterface

interface spq_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_tag;
  logic [6:0] out_score;
  logic [4:0] waiting_count;
  logic [4:0] critical_count;
  logic [4:0] urgent_count;
  logic [4:0] nonurgent_count;

  modport source (output valid, status, out_tag, out_score, waiting_count, critical_count,
                  urgent_count, nonurgent_count, input ready);
  modport sink   (input valid, status, out_tag, out_score, waiting_count, critical_count,
                  urgent_count, nonurgent_count, output ready);
endinterface

/* hdl/spq_front.sv */
// ----------------------------------------------------------------------------
// Scored priority queue front end
// Accepts request words, computes the score and class of inserts.
// ----------------------------------------------------------------------------
module spq_front (
  spq_req_if.sink          req_i,
  output logic             cmd_valid_o,
  output spq_pkg::spq_cmd_t cmd_o,
  input  logic             cmd_ready_i
);

  logic [spq_pkg::SCORE_W-1:0] base;
  logic [spq_pkg::SCORE_W-1:0] age_bonus;
  logic [spq_pkg::SCORE_W-1:0] pain_bonus;
  spq_pkg::spq_class_e         cls;

  always_comb begin
    priority if (req_i.severity == spq_pkg::SEV_CRIT) begin
      base = spq_pkg::SCORE_CRIT;
      cls  = spq_pkg::CLS_CRIT;
    end else if (req_i.severity == spq_pkg::SEV_URG) begin
      base = spq_pkg::SCORE_URG;
      cls  = spq_pkg::CLS_URG;
    end else begin
      base = spq_pkg::SCORE_NON;
      cls  = spq_pkg::CLS_NON;
    end

    priority if (req_i.age >= spq_pkg::AGE_OLD) begin
      age_bonus = spq_pkg::BONUS_HIGH;
    end else if (req_i.age <= spq_pkg::AGE_YOUNG) begin
      age_bonus = spq_pkg::BONUS_LOW;
    end else begin
      age_bonus = '0;
    end

    pain_bonus = (req_i.pain_level > spq_pkg::PAIN_HIGH) ? spq_pkg::BONUS_HIGH
                                                         : spq_pkg::BONUS_LOW;
  end

  assign cmd_o.is_pop = (req_i.req_type == spq_pkg::REQ_POP);
  assign cmd_o.tag    = req_i.tag[spq_pkg::STAG_W-1:0];
  assign cmd_o.score  = base + age_bonus + pain_bonus;
  assign cmd_o.cls    = cls;

  assign cmd_valid_o = req_i.valid;
  assign req_i.ready = cmd_ready_i;

endmodule

/* hdl/spq_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Scored priority queue command FIFO
// Short queue of classified command words between front and back.
// ----------------------------------------------------------------------------
module spq_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  spq_pkg::spq_cmd_t in_cmd_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output spq_pkg::spq_cmd_t out_cmd_o,
  input  logic              out_ready_i
);

  localparam int PTR_W = (spq_pkg::FIFO_DEPTH > 1) ? $clog2(spq_pkg::FIFO_DEPTH) : 1;
  localparam int FCNT_W = $clog2(spq_pkg::FIFO_DEPTH + 1);

  spq_pkg::spq_cmd_t mem_q [spq_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign in_ready_o  = (cnt_q != FCNT_W'(spq_pkg::FIFO_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_cmd_o   = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(spq_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(spq_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    priority if (push && !pop) begin
      cnt_d = cnt_q + FCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - FCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule

/* hdl/spq_back.sv */
// ----------------------------------------------------------------------------
// Scored priority queue back end
// Sorted shift-register store; executes inserts and pops and registers words.
// ----------------------------------------------------------------------------
module spq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  spq_pkg::spq_cmd_t cmd_i,
  output logic              cmd_ready_o,
  spq_rsp_if.source         rsp_o
);

  localparam int D = spq_pkg::QUEUE_DEPTH;
  localparam int W = spq_pkg::CNT_W;

  typedef struct packed {
    spq_pkg::spq_status_e                status;
    logic [spq_pkg::STAG_W-1:0]          tag;
    logic [spq_pkg::SCORE_W-1:0]         score;
    logic [W-1:0]                        occ;
    logic [W-1:0]                        crit;
    logic [W-1:0]                        urg;
    logic [W-1:0]                        non;
  } spq_rsp_t;

  logic [spq_pkg::STAG_W-1:0]  slot_tag_q   [D];
  logic [spq_pkg::SCORE_W-1:0] slot_score_q [D];
  spq_pkg::spq_class_e         slot_cls_q   [D];
  logic [W-1:0]                occ_q, occ_d;
  logic [W-1:0]                cnt_q [3];
  logic [W-1:0]                cnt_d [3];
  logic [D-1:0]                keep;
  logic                        take, full, empty, do_ins, do_pop;
  logic                        rsp_valid_q;
  spq_rsp_t                    rsp_q, rsp_d;

  assign cmd_ready_o = !rsp_valid_q || rsp_o.ready;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign full        = (occ_q == W'(D));
  assign empty       = (occ_q == '0);
  assign do_ins      = take && !cmd_i.is_pop && !full;
  assign do_pop      = take && cmd_i.is_pop && !empty;

  for (genvar g = 0; g < D; g++) begin : g_slot
    assign keep[g] = (W'(g) < occ_q) && (slot_score_q[g] >= cmd_i.score);

    always_ff @(posedge clk_i) begin
      if (do_ins && !keep[g]) begin
        if (g == 0) begin
          slot_tag_q[g]   <= cmd_i.tag;
          slot_score_q[g] <= cmd_i.score;
          slot_cls_q[g]   <= cmd_i.cls;
        end else if (keep[(g > 0) ? g - 1 : 0]) begin
          slot_tag_q[g]   <= cmd_i.tag;
          slot_score_q[g] <= cmd_i.score;
          slot_cls_q[g]   <= cmd_i.cls;
        end else begin
          slot_tag_q[g]   <= slot_tag_q[(g > 0) ? g - 1 : 0];
          slot_score_q[g] <= slot_score_q[(g > 0) ? g - 1 : 0];
          slot_cls_q[g]   <= slot_cls_q[(g > 0) ? g - 1 : 0];
        end
      end else if (do_pop && (g < D - 1)) begin
        slot_tag_q[g]   <= slot_tag_q[(g < D - 1) ? g + 1 : g];
        slot_score_q[g] <= slot_score_q[(g < D - 1) ? g + 1 : g];
        slot_cls_q[g]   <= slot_cls_q[(g < D - 1) ? g + 1 : g];
      end
    end
  end

  always_comb begin
    occ_d = occ_q;
    cnt_d = cnt_q;
    if (do_ins) begin
      occ_d            = occ_q + W'(1);
      cnt_d[cmd_i.cls] = cnt_q[cmd_i.cls] + W'(1);
    end
    if (do_pop) begin
      occ_d                = occ_q - W'(1);
      cnt_d[slot_cls_q[0]] = cnt_q[slot_cls_q[0]] - W'(1);
    end

    rsp_d.status = spq_pkg::ST_OK;
    rsp_d.tag    = cmd_i.tag;
    rsp_d.score  = cmd_i.score;
    if (cmd_i.is_pop) begin
      if (empty) begin
        rsp_d.status = spq_pkg::ST_EMPTY;
        rsp_d.tag    = '0;
        rsp_d.score  = '0;
      end else begin
        rsp_d.tag    = slot_tag_q[0];
        rsp_d.score  = slot_score_q[0];
      end
    end else if (full) begin
      rsp_d.status = spq_pkg::ST_FULL;
    end
    rsp_d.occ  = occ_d;
    rsp_d.crit = cnt_d[spq_pkg::CLS_CRIT];
    rsp_d.urg  = cnt_d[spq_pkg::CLS_URG];
    rsp_d.non  = cnt_d[spq_pkg::CLS_NON];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      cnt_q[2]    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      cnt_q <= cnt_d;
      if (take) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_q.status;
  assign rsp_o.out_tag         = spq_pkg::tag_out(rsp_q.tag);
  assign rsp_o.out_score       = rsp_q.score;
  assign rsp_o.waiting_count   = spq_pkg::count_out(rsp_q.occ);
  assign rsp_o.critical_count  = spq_pkg::count_out(rsp_q.crit);
  assign rsp_o.urgent_count    = spq_pkg::count_out(rsp_q.urg);
  assign rsp_o.nonurgent_count = spq_pkg::count_out(rsp_q.non);

endmodule

/* hdl/scored_priority_queue.sv */
// Request words are held in the command FIFO and responses in the response register.
// Throughput: one request word per cycle unless stalled; the sorted store is updated
// by per-slot compare and shift, and the response register frees as it is taken.
// Reset: asynchronous, active low; the queue is empty and all counts are zero at once.
// ----------------------------------------------------------------------------
// Scored priority queue
// Front end classifies requests, a command FIFO decouples it from the sorted store.
// ----------------------------------------------------------------------------
module scored_priority_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  logic              f_valid, f_ready;
  spq_pkg::spq_cmd_t f_cmd;
  logic              b_valid, b_ready;
  spq_pkg::spq_cmd_t b_cmd;

  spq_front u_front (
    .req_i       (req_i),
    .cmd_valid_o (f_valid),
    .cmd_o       (f_cmd),
    .cmd_ready_i (f_ready)
  );

  spq_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_cmd_i    (f_cmd),
    .in_ready_o  (f_ready),
    .out_valid_o (b_valid),
    .out_cmd_o   (b_cmd),
    .out_ready_i (b_ready)
  );

  spq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_i       (b_cmd),
    .cmd_ready_o (b_ready),
    .rsp_o       (rsp_o)
  );

endmodule

/* hdl/spq_checker.sv */
// ----------------------------------------------------------------------------
// Scored priority queue checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [1:0] status_i,
  input logic [7:0] out_tag_i,
  input logic [6:0] out_score_i,
  input logic [4:0] waiting_count_i,
  input logic [4:0] critical_count_i,
  input logic [4:0] urgent_count_i,
  input logic [4:0] nonurgent_count_i
);

  logic [4:0] class_sum;
  logic [4:0] depth_code;

  assign class_sum  = critical_count_i + urgent_count_i + nonurgent_count_i;
  assign depth_code = spq_pkg::count_out(spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));

  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(status_i) && $stable(out_tag_i) && $stable(waiting_count_i))
  `ASSERT_SAME(a_count_sum, clk_i, rst_ni, rsp_valid_i, class_sum == waiting_count_i)
  `ASSERT_SAME(a_empty_word, clk_i, rst_ni, rsp_valid_i && (status_i == spq_pkg::ST_EMPTY), (out_tag_i == 8'd0) && (out_score_i == 7'd0) && (waiting_count_i == 5'd0))
  `ASSERT_SAME(a_full_word, clk_i, rst_ni, rsp_valid_i && (status_i == spq_pkg::ST_FULL), waiting_count_i == depth_code)

endmodule

bind scored_priority_queue spq_checker u_spq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .status_i          (rsp_o.status),
  .out_tag_i         (rsp_o.out_tag),
  .out_score_i       (rsp_o.out_score),
  .waiting_count_i   (rsp_o.waiting_count),
  .critical_count_i  (rsp_o.critical_count),
  .urgent_count_i    (rsp_o.urgent_count),
  .nonurgent_count_i (rsp_o.nonurgent_count)
);

/* test/scored_priority_queue_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scored priority queue testbench
// Offers insert and pop words with random idling on both sides and a long
// response hold-off, predicts each response with a sorted ward model, and
// compares every response field by field in order.
// ----------------------------------------------------------------------------
module scored_priority_queue_tb;

  localparam logic [1:0] SEV_ROUTINE    = 2'd0;
  localparam logic [1:0] SEV_MINOR      = 2'd1;
  localparam int         RANDOM_WORDS   = 500;
  localparam int         HOLD_CYCLES    = 80;
  localparam int         DRAIN_CYCLES   = 8;
  localparam int         WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    spq_pkg::spq_req_e kind;
    logic [7:0]        tag;
    logic [1:0]        sev;
    logic [6:0]        age;
    logic [3:0]        pain;
  } triage_word_t;

  typedef struct packed {
    spq_pkg::spq_status_e status;
    logic [7:0]           tag;
    logic [6:0]           score;
    logic [4:0]           waiting;
    logic [4:0]           crit;
    logic [4:0]           urg;
    logic [4:0]           non;
  } triage_rsp_t;

  typedef struct {
    logic [7:0]          tag;
    logic [6:0]          score;
    spq_pkg::spq_class_e cls;
  } ward_slot_t;

  typedef struct {
    triage_word_t word;
    bit           pinned;
    triage_rsp_t  rsp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic calm;
  logic hold_go;

  spq_req_if req_bus ();
  spq_rsp_if rsp_bus ();

  scored_priority_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #10 clk_i = ~clk_i;

  ward_slot_t  ward[$];
  int          class_tally[3];
  triage_rsp_t due_rsp[$];
  stim_row_t   offered_rows[$];
  stim_row_t   stim_rows[$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  function automatic triage_rsp_t predict_triage(triage_word_t w);
    triage_rsp_t r;
    ward_slot_t  s;
    int          pos;
    r = '0;
    r.status = spq_pkg::ST_OK;
    if (w.kind == spq_pkg::REQ_INSERT) begin
      s.tag = w.tag;
      s.cls = (w.sev == spq_pkg::SEV_CRIT) ? spq_pkg::CLS_CRIT :
              (w.sev == spq_pkg::SEV_URG)  ? spq_pkg::CLS_URG  : spq_pkg::CLS_NON;
      s.score = (w.sev == spq_pkg::SEV_CRIT) ? 7'd50 :
                (w.sev == spq_pkg::SEV_URG)  ? 7'd30 : 7'd10;
      if (w.age >= 7'd65) begin
        s.score += 7'd10;
      end else if (w.age <= 7'd12) begin
        s.score += 7'd5;
      end
      s.score += (w.pain > 4'd5) ? 7'd10 : 7'd5;
      r.tag = s.tag;
      r.score = s.score;
      if (ward.size() >= spq_pkg::QUEUE_DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < ward.size() && ward[pos].score >= s.score) pos++;
        ward.insert(pos, s);
        class_tally[s.cls]++;
      end
    end else if (ward.size() == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      s = ward.pop_front();
      r.tag = s.tag;
      r.score = s.score;
      class_tally[s.cls]--;
    end
    r.waiting = 5'(ward.size());
    r.crit = 5'(class_tally[spq_pkg::CLS_CRIT]);
    r.urg = 5'(class_tally[spq_pkg::CLS_URG]);
    r.non = 5'(class_tally[spq_pkg::CLS_NON]);
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
      mismatches++;
    end
  endfunction

  task automatic plain_row(spq_pkg::spq_req_e kind, logic [7:0] tag, logic [1:0] sev,
                           logic [6:0] age, logic [3:0] pain);
    stim_row_t row;
    row.word = '{kind, tag, sev, age, pain};
    row.pinned = 1'b0;
    row.rsp = '0;
    stim_rows.push_back(row);
  endtask

  task automatic pinned_row(spq_pkg::spq_req_e kind, logic [7:0] tag, logic [1:0] sev,
                            logic [6:0] age, logic [3:0] pain,
                            spq_pkg::spq_status_e status,
                            logic [7:0] otag, logic [6:0] oscore, logic [4:0] waiting,
                            logic [4:0] crit, logic [4:0] urg, logic [4:0] non);
    stim_row_t row;
    row.word = '{kind, tag, sev, age, pain};
    row.pinned = 1'b1;
    row.rsp = '{status, otag, oscore, waiting, crit, urg, non};
    stim_rows.push_back(row);
  endtask

  task automatic idle_gap();
    while (!calm && $urandom_range(99) < 36) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic offer(stim_row_t row);
    offered_rows.push_back(row);
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= row.word.kind;
    req_bus.tag        <= row.word.tag;
    req_bus.severity   <= row.word.sev;
    req_bus.age        <= row.word.age;
    req_bus.pain_level <= row.word.pain;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (due_rsp.size() != 0 || offered_rows.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    stim_row_t row;
    int        k;
    int        insert_pct;
    rst_ni = 1'b0;
    calm = 1'b0;
    hold_go = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.req_type = spq_pkg::REQ_INSERT;
    req_bus.tag = '0;
    req_bus.severity = '0;
    req_bus.age = '0;
    req_bus.pain_level = '0;

    pinned_row(spq_pkg::REQ_POP, 8'h00, SEV_ROUTINE, 7'd0, 4'd0, spq_pkg::ST_EMPTY,
               8'h00, 7'd0, 5'd0, 5'd0, 5'd0, 5'd0);
    pinned_row(spq_pkg::REQ_INSERT, 8'hFF, spq_pkg::SEV_CRIT, 7'd127, 4'd15, spq_pkg::ST_OK,
               8'hFF, 7'd70, 5'd1, 5'd1, 5'd0, 5'd0);
    pinned_row(spq_pkg::REQ_INSERT, 8'h00, SEV_ROUTINE, 7'd0, 4'd0, spq_pkg::ST_OK,
               8'h00, 7'd20, 5'd2, 5'd1, 5'd0, 5'd1);
    pinned_row(spq_pkg::REQ_INSERT, 8'h5A, spq_pkg::SEV_URG, 7'd12, 4'd5, spq_pkg::ST_OK,
               8'h5A, 7'd40, 5'd3, 5'd1, 5'd1, 5'd1);
    plain_row(spq_pkg::REQ_INSERT, 8'hA5, SEV_MINOR, 7'd13, 4'd6);
    plain_row(spq_pkg::REQ_INSERT, 8'h3C, spq_pkg::SEV_URG, 7'd64, 4'd10);
    plain_row(spq_pkg::REQ_INSERT, 8'hC3, spq_pkg::SEV_CRIT, 7'd65, 4'd0);
    plain_row(spq_pkg::REQ_POP, 8'h00, SEV_ROUTINE, 7'd0, 4'd0);
    for (k = 0; k < 11; k++) begin
      plain_row(spq_pkg::REQ_INSERT, 8'(16 * k + 1), 2'(k), 7'(12 * k), 4'(k + 3));
    end
    plain_row(spq_pkg::REQ_INSERT, 8'h81, spq_pkg::SEV_URG, 7'd70, 4'd11);
    plain_row(spq_pkg::REQ_POP, 8'h00, SEV_ROUTINE, 7'd0, 4'd0);
    plain_row(spq_pkg::REQ_POP, 8'hFF, spq_pkg::SEV_CRIT, 7'd127, 4'd15);
    plain_row(spq_pkg::REQ_POP, 8'h00, SEV_ROUTINE, 7'd0, 4'd0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      idle_gap();
      offer(stim_rows[i]);
    end

    for (k = 0; k < RANDOM_WORDS; k++) begin
      if (k == 100) calm <= 1'b1;
      if (k == 200) calm <= 1'b0;
      if (k == 260) hold_go <= 1'b1;
      if (k == 380) wait_drained();
      unique case ((k / 50) % 3)
        0:       insert_pct = 80;
        1:       insert_pct = 20;
        default: insert_pct = 50;
      endcase
      row.word.kind = ($urandom_range(99) < insert_pct) ? spq_pkg::REQ_INSERT
                                                        : spq_pkg::REQ_POP;
      row.word.tag = 8'($urandom_range(255));
      row.word.sev = 2'($urandom_range(3));
      row.word.age = 7'($urandom_range(127));
      row.word.pain = 4'($urandom_range(15));
      row.pinned = 1'b0;
      row.rsp = '0;
      idle_gap();
      offer(row);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : receiver
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    triage_word_t w;
    triage_rsp_t  want;
    triage_rsp_t  seen;
    stim_row_t    row;
    bit           progress;
    if (rst_ni) begin
      progress = 1'b0;
      if (req_bus.valid && req_bus.ready) begin
        progress = 1'b1;
        w.kind = spq_pkg::spq_req_e'(req_bus.req_type);
        w.tag = req_bus.tag;
        w.sev = req_bus.severity;
        w.age = req_bus.age;
        w.pain = req_bus.pain_level;
        want = predict_triage(w);
        if (offered_rows.size() != 0) begin
          row = offered_rows.pop_front();
          if (row.pinned) want = row.rsp;
        end
        due_rsp.push_back(want);
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        progress = 1'b1;
        seen.status = spq_pkg::spq_status_e'(rsp_bus.status);
        seen.tag = rsp_bus.out_tag;
        seen.score = rsp_bus.out_score;
        seen.waiting = rsp_bus.waiting_count;
        seen.crit = rsp_bus.critical_count;
        seen.urg = rsp_bus.urgent_count;
        seen.non = rsp_bus.nonurgent_count;
        if (due_rsp.size() == 0) begin
          $display("%0t: response word with none expected, got status %0d tag %0d",
                   $time, seen.status, seen.tag);
          mismatches++;
        end else begin
          want = due_rsp.pop_front();
          check_field("status", want.status, seen.status);
          check_field("out_tag", want.tag, seen.tag);
          check_field("out_score", want.score, seen.score);
          check_field("waiting_count", want.waiting, seen.waiting);
          check_field("critical_count", want.crit, seen.crit);
          check_field("urgent_count", want.urg, seen.urg);
          check_field("nonurgent_count", want.non, seen.non);
        end
      end
      if (!progress && idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
      idle_cycles <= progress ? 0 : idle_cycles + 1;
    end
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_if.sv
hdl/spq_front.sv
hdl/spq_cmd_fifo.sv
hdl/spq_back.sv
hdl/scored_priority_queue.sv
hdl/spq_checker.sv
test/scored_priority_queue_tb.sv
